/* sv/matrix_multiply_engine_top_defines.svh */
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top_defines
// assertion macros shared by the matrix multiply engine
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH

// checked on every clock edge outside reset
`define MME_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define MME_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/mme_pkg.sv */
// ----------------------------------------------------------------------------
// mme_pkg
// shared types and constants of the matrix multiply engine
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  localparam int unsigned MME_MAX_DIM = 16;
  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned REG_W       = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned OUT_IDX_W   = 4;

  localparam logic [PROD_W-1:0] SAT_MAX = {1'b0, {(PROD_W-1){1'b1}}};
  localparam logic [PROD_W-1:0] SAT_MIN = {1'b1, {(PROD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_LEN = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_STREAM = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic clr;
    logic capture;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/mme_ram.sv */
// ----------------------------------------------------------------------------
// mme_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/mme_cell.sv */
// ----------------------------------------------------------------------------
// mme_cell
// one column cell: accumulates the products tagged with its column, passes
// other products on, and shifts captured sums toward the output end
// ----------------------------------------------------------------------------
`default_nettype none

module mme_cell
  import mme_pkg::*;
#(
  parameter int unsigned MAX_DIM = MME_MAX_DIM,
  parameter int unsigned IDX     = 0
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire cell_ctrl_t                            ctrl_i,
  input  wire logic                                  tok_vld_i,
  input  wire logic        [$clog2(MAX_DIM)-1:0]     tok_col_i,
  input  wire logic signed [PROD_W-1:0]              tok_prod_i,
  output logic                                       tok_vld_o,
  output logic             [$clog2(MAX_DIM)-1:0]     tok_col_o,
  output logic signed      [PROD_W-1:0]              tok_prod_o,
  input  wire logic signed [33+$clog2(MAX_DIM)-1:0]  shadow_i,
  output logic signed      [33+$clog2(MAX_DIM)-1:0]  shadow_o
);

  localparam int unsigned COL_W = $clog2(MAX_DIM);
  localparam int unsigned ACC_W = 33 + $clog2(MAX_DIM);

  logic                     hit;
  logic                     tok_vld_q;
  logic        [COL_W-1:0]  tok_col_q;
  logic signed [PROD_W-1:0] tok_prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  shadow_q;

  assign hit = tok_vld_i && (tok_col_i == COL_W'(IDX));

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr || ctrl_i.capture) begin
      acc_d = '0;
    end else if (hit) begin
      acc_d = acc_q + ACC_W'(tok_prod_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      tok_vld_q <= tok_vld_i && !hit;
      acc_q     <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_col_q  <= tok_col_i;
    tok_prod_q <= tok_prod_i;
    if (ctrl_i.capture) begin
      shadow_q <= acc_q;
    end else if (ctrl_i.shift) begin
      shadow_q <= shadow_i;
    end
  end

  assign tok_vld_o  = tok_vld_q;
  assign tok_col_o  = tok_col_q;
  assign tok_prod_o = tok_prod_q;
  assign shadow_o   = shadow_q;

endmodule

`default_nettype wire

/* sv/matrix_multiply_engine_top.sv */
// load item (operation 0): one weight ram write
// stream item (operation 1): one product a time from the weight ram
//   port, each product carried down the column cells to its accumulator
// the last item of a row is followed by cols_b results, one per accepted output
// after reset a clearing pass zeroes all MAX_DIM*MAX_DIM weight ram entries
//   with no item accepted; configuration writes are taken throughout
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top
// dense fixed point matrix product with a weight ram and a chain of column cells
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_multiply_engine_top_defines.svh"

module matrix_multiply_engine_top
  import mme_pkg::*;
#(
  parameter int unsigned MAX_DIM = MME_MAX_DIM
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [REG_W-1:0]         cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     operation_i,
  input  wire logic signed [ELEM_W-1:0] element_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [PROD_W-1:0]      product_o,
  output logic [OUT_IDX_W-1:0]          out_row_o,
  output logic [OUT_IDX_W-1:0]          out_col_o,
  output logic                          last_of_row_o,
  output logic                          last_of_matrix_o,
  output logic                          saturated_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SZ_W  = $clog2(DEPTH + 1);
  localparam int unsigned COL_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned ACC_W = 33 + $clog2(MAX_DIM);
  localparam int unsigned CMP_W = (DIM_W > REG_W) ? DIM_W : REG_W;

  function automatic logic [DIM_W-1:0] dim_of(input logic [REG_W-1:0] v);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    if (v == '0) begin
      dim_of = DIM_W'(1);
    end else if (ext > CMP_W'(MAX_DIM)) begin
      dim_of = DIM_W'(MAX_DIM);
    end else begin
      dim_of = DIM_W'(ext);
    end
  endfunction

  state_e state_q, state_d;

  logic [REG_W-1:0] rows_a_q, inner_len_q, cols_b_q;
  logic [DIM_W-1:0] nr, nk, nc;
  logic [SZ_W-1:0]  store_size;

  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [AW-1:0]    fill_q, fill_d;
  logic [AW-1:0]    load_idx, fill_next;
  logic [SZ_W-1:0]  load_inc;
  logic [COL_W-1:0] inner_q, inner_d;
  logic [COL_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;

  logic             k_restart;
  logic [COL_W-1:0] k_eff;
  logic             k_is_last;
  logic [COL_W-1:0] row_eff;
  logic [DIM_W-1:0] row_inc;
  logic [COL_W-1:0] row_next;
  logic             col_last;

  logic signed [ELEM_W-1:0] a_q;
  logic [AW-1:0]            base_q;
  logic [COL_W-1:0]         k_q;
  logic                     klast_q;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ELEM_W-1:0] ram_wdata, ram_rdata;

  logic                     rd_vld_q;
  logic [COL_W-1:0]         rd_col_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic [COL_W-1:0]         prod_col_q;
  logic                     prod_vld_q;
  logic                     busy;

  cell_ctrl_t cell_ctrl;

  logic        [MAX_DIM:0] chain_vld;
  logic        [COL_W-1:0] chain_col  [MAX_DIM+1];
  logic signed [PROD_W-1:0] chain_prod [MAX_DIM+1];
  logic signed [ACC_W-1:0] chain_sh   [MAX_DIM+1];

  logic signed [ACC_W-1:0]     head;
  logic [ACC_W-PROD_W:0]       head_hi;
  logic                        head_sat;

  // shapes and load addressing
  assign nr         = dim_of(rows_a_q);
  assign nk         = dim_of(inner_len_q);
  assign nc         = dim_of(cols_b_q);
  assign store_size = SZ_W'(nk) * SZ_W'(nc);

  assign load_idx  = (SZ_W'(fill_q) < store_size) ? fill_q : '0;
  assign load_inc  = SZ_W'(load_idx) + SZ_W'(1);
  assign fill_next = (load_inc >= store_size) ? '0 : AW'(load_inc);

  assign k_restart = DIM_W'(inner_q) >= nk;
  assign k_eff     = k_restart ? '0 : inner_q;
  assign k_is_last = (DIM_W'(k_eff) + DIM_W'(1)) >= nk;

  assign row_eff  = (DIM_W'(row_q) < nr) ? row_q : '0;
  assign row_inc  = DIM_W'(row_eff) + DIM_W'(1);
  assign row_next = (row_inc >= nr) ? '0 : COL_W'(row_inc);

  assign col_last  = DIM_W'(col_q) == (nc - DIM_W'(1));
  assign ram_raddr = base_q + AW'(col_q);

  assign busy = rd_vld_q | (|chain_vld);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= REG_W'(1);
      inner_len_q <= REG_W'(1);
      cols_b_q    <= REG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        CFG_INNER_LEN: inner_len_q <= cfg_data_i;
        CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    fill_d      = fill_q;
    inner_d     = inner_q;
    row_d       = row_q;
    col_d       = col_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    cell_ctrl   = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (operation_i == OP_LOAD) begin
            ram_we    = 1'b1;
            ram_waddr = load_idx;
            ram_wdata = element_i;
            fill_d    = fill_next;
          end else begin
            cell_ctrl.clr = k_restart;
            col_d         = '0;
            state_d       = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        ram_re = 1'b1;
        col_d  = col_q + COL_W'(1);
        if (col_last) begin
          col_d   = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!busy) begin
          if (klast_q) begin
            cell_ctrl.capture = 1'b1;
            state_d           = S_EMIT;
          end else begin
            inner_d = k_q + COL_W'(1);
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cell_ctrl.shift = 1'b1;
          col_d           = col_q + COL_W'(1);
          if (col_last) begin
            col_d   = '0;
            inner_d = '0;
            row_d   = row_next;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_cnt_q  <= '0;
      fill_q     <= '0;
      inner_q    <= '0;
      row_q      <= '0;
      col_q      <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      fill_q     <= fill_d;
      inner_q    <= inner_d;
      row_q      <= row_d;
      col_q      <= col_d;
      rd_vld_q   <= ram_re;
      prod_vld_q <= rd_vld_q;
    end
  end

  assign prod_d = a_q * signed'(ram_rdata);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o && (operation_i == OP_STREAM)) begin
      a_q     <= element_i;
      base_q  <= AW'(SZ_W'(k_eff) * SZ_W'(nc));
      k_q     <= k_eff;
      klast_q <= k_is_last;
    end
    rd_col_q   <= col_q;
    prod_q     <= prod_d;
    prod_col_q <= rd_col_q;
  end

  mme_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign chain_vld[0]      = prod_vld_q;
  assign chain_col[0]      = prod_col_q;
  assign chain_prod[0]     = prod_q;
  assign chain_sh[MAX_DIM] = '0;

  for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
    mme_cell #(
      .MAX_DIM (MAX_DIM),
      .IDX     (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .tok_vld_i  (chain_vld[i]),
      .tok_col_i  (chain_col[i]),
      .tok_prod_i (chain_prod[i]),
      .tok_vld_o  (chain_vld[i+1]),
      .tok_col_o  (chain_col[i+1]),
      .tok_prod_o (chain_prod[i+1]),
      .shadow_i   (chain_sh[i+1]),
      .shadow_o   (chain_sh[i])
    );
  end

  // saturate the head of the shadow chain
  assign head     = chain_sh[0];
  assign head_hi  = head[ACC_W-1:PROD_W-1];
  assign head_sat = (|head_hi) && !(&head_hi);

  assign product_o        = head_sat ? (head[ACC_W-1] ? SAT_MIN : SAT_MAX)
                                     : head[PROD_W-1:0];
  assign saturated_o      = head_sat;
  assign out_row_o        = OUT_IDX_W'(row_eff);
  assign out_col_o        = OUT_IDX_W'(col_q);
  assign last_of_row_o    = col_last;
  assign last_of_matrix_o = col_last && (DIM_W'(row_eff) == (nr - DIM_W'(1)));

  `MME_ASSERT_CLK(a_ready_excl_out, in_ready_o |-> !out_valid_o, "input ready while emitting")
  `MME_ASSERT_CLK(a_lom_has_lor, out_valid_o && last_of_matrix_o |-> last_of_row_o,
                  "last of matrix without last of row")
  `MME_ASSERT_CLK(a_row_end_idle, out_valid_o && out_ready_i && last_of_row_o |=> in_ready_o,
                  "no return to idle after row")
  `MME_ASSERT_CLK(a_stream_issues,
                  in_valid_i && in_ready_o && (operation_i == OP_STREAM) |=> state_q == S_ISSUE,
                  "stream item did not start issue")
  `MME_ASSERT_CLK(a_idle_chain_empty, state_q == S_IDLE |-> !busy, "products in flight in idle")
  `MME_ASSERT_ANY(a_reset_quiet, !rst_ni |=> !in_ready_o && !out_valid_o,
                  "handshake active in reset")

endmodule

`default_nettype wire
